@@ rtl/gbp_pkg.sv @@
// gbp_pkg: shared constants, types and helpers for the gshare branch predictor.
// No dependencies; imported by every module of the block.
package gbp_pkg;

    localparam int INDEX_BITS   = 12;
    localparam int TABLE_SIZE   = 1 << INDEX_BITS;
    localparam int HIST_BITS    = 12;
    localparam int HIST_MAX_EFF = (HIST_BITS < INDEX_BITS) ? HIST_BITS : INDEX_BITS;
    localparam int SH_W         = $clog2(INDEX_BITS + 1);
    localparam int CFG_W        = 4;
    localparam int CNT_W        = 32;
    localparam int Q_DEPTH      = 2;
    localparam int Q_CNT_W      = $clog2(Q_DEPTH + 1);
    localparam int Q_PTR_W      = $clog2(Q_DEPTH);

    typedef logic [INDEX_BITS-1:0] t_idx;
    typedef logic [HIST_BITS-1:0]  t_hist;
    typedef logic [1:0]            t_ctr;
    typedef logic [SH_W-1:0]       t_nlen;

    localparam t_ctr CTR_INIT = 2'b10;   // weakly taken
    localparam t_ctr CTR_MAX  = 2'b11;
    localparam t_ctr CTR_MIN  = 2'b00;

    typedef struct packed {
        t_idx idx;
        logic taken;
    } t_mid_item;

    typedef struct packed {
        logic             predicted_taken;
        logic             mispredicted;
        logic [CNT_W-1:0] branch_count;
        logic [CNT_W-1:0] mispredict_count;
    } t_result;

    // Saturating 2-bit counter training.
    function automatic t_ctr ctr_train(input t_ctr ctr, input logic taken);
        t_ctr r;
        r = ctr;
        if (taken) begin
            if (ctr != CTR_MAX) r = ctr + 2'd1;
        end else begin
            if (ctr != CTR_MIN) r = ctr - 2'd1;
        end
        return r;
    endfunction

endpackage

@@ rtl/gbp_front.sv @@
// gbp_front: history register, config register, table index hashing and the
// queue that hands indexed branches to the back end. Depends on gbp_pkg.
module gbp_front import gbp_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    input  logic             i_push,
    input  logic [31:0]      i_pc,
    input  logic             i_taken,
    output logic             o_full,
    output logic             o_head_vld,
    output t_mid_item        o_head,
    input  logic             i_head_pop
);

    logic [CFG_W-1:0]   r_hist_bits;
    t_hist              r_hist, n_hist;
    t_nlen              n_eff, shamt;
    t_hist              hmask, hist_m;
    logic [INDEX_BITS+HIST_BITS-1:0] hist_wide;
    t_idx               idx;

    t_mid_item          r_q [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [Q_CNT_W-1:0] r_cnt;

    // effective history length: saturate to history width and index width
    always_comb begin
        if (32'(r_hist_bits) > HIST_MAX_EFF) n_eff = t_nlen'(HIST_MAX_EFF);
        else                                 n_eff = t_nlen'(r_hist_bits);
    end

    always_comb begin
        for (int i = 0; i < HIST_BITS; i++) hmask[i] = (i < int'(n_eff));
        hist_m    = r_hist & hmask;
        shamt     = t_nlen'(INDEX_BITS) - n_eff;
        hist_wide = (INDEX_BITS + HIST_BITS)'(hist_m) << shamt;
        idx       = i_pc[INDEX_BITS+1:2] ^ hist_wide[INDEX_BITS-1:0];
        if (n_eff == '0) n_hist = '0;
        else             n_hist = (hist_m >> 1) | (t_hist'(i_taken) << (n_eff - t_nlen'(1)));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist_bits <= '0;
            r_hist      <= '0;
        end else begin
            if (i_cfg_we) r_hist_bits <= i_cfg_wdata;
            if (i_push)   r_hist      <= n_hist;
        end
    end

    // hand-off queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_push)     r_wr_ptr <= r_wr_ptr + Q_PTR_W'(1);
            if (i_head_pop) r_rd_ptr <= r_rd_ptr + Q_PTR_W'(1);
            r_cnt <= r_cnt + Q_CNT_W'(i_push) - Q_CNT_W'(i_head_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_q[r_wr_ptr] <= '{idx: idx, taken: i_taken};
    end

    assign o_full     = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign o_head_vld = (r_cnt != '0);
    assign o_head     = r_q[r_rd_ptr];

endmodule

@@ rtl/gbp_back.sv @@
// gbp_back: counter table with its clearing pass, read/train/write stage,
// running counts and the result queue. Depends on gbp_pkg.
module gbp_back import gbp_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_head_vld,
    input  t_mid_item i_head,
    output logic      o_head_pop,
    output logic      o_clr_busy,
    output logic      o_empty,
    output t_result   o_result,
    input  logic      i_pop
);

    t_ctr               r_mem [TABLE_SIZE];
    logic               r_clr_busy;
    t_idx               r_clr_addr;

    logic               r_b_vld;
    t_mid_item          r_b_item;
    t_ctr               r_rd_data;

    logic               r_lw_vld;
    t_idx               r_lw_idx;
    t_ctr               r_lw_ctr;

    logic [CNT_W-1:0]   r_br_cnt, r_mis_cnt;

    t_result            r_rq [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [Q_CNT_W-1:0] r_cnt;

    logic               rq_full, b_done, adv, pred, miss;
    t_ctr               ctr, n_ctr;
    t_result            res;

    assign rq_full = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign b_done  = r_b_vld && !rq_full;
    assign adv     = i_head_vld && !r_clr_busy && (!r_b_vld || b_done);

    // newest write wins over the registered read data
    always_comb begin
        ctr   = (r_lw_vld && (r_lw_idx == r_b_item.idx)) ? r_lw_ctr : r_rd_data;
        pred  = ctr[1];
        miss  = pred ^ r_b_item.taken;
        n_ctr = ctr_train(ctr, r_b_item.taken);
        res.predicted_taken  = pred;
        res.mispredicted     = miss;
        res.branch_count     = r_br_cnt + CNT_W'(1);
        res.mispredict_count = r_mis_cnt + CNT_W'(miss);
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy)  r_mem[r_clr_addr] <= CTR_INIT;
        else if (b_done) r_mem[r_b_item.idx] <= n_ctr;
        if (adv)         r_rd_data <= r_mem[i_head.idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
            r_b_vld    <= 1'b0;
            r_lw_vld   <= 1'b0;
            r_br_cnt   <= '0;
            r_mis_cnt  <= '0;
        end else begin
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + t_idx'(1);
                if (r_clr_addr == t_idx'(TABLE_SIZE - 1)) r_clr_busy <= 1'b0;
            end
            if (adv)         r_b_vld <= 1'b1;
            else if (b_done) r_b_vld <= 1'b0;
            if (b_done) begin
                r_lw_vld  <= 1'b1;
                r_br_cnt  <= res.branch_count;
                r_mis_cnt <= res.mispredict_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) r_b_item <= i_head;
        if (b_done) begin
            r_lw_idx <= r_b_item.idx;
            r_lw_ctr <= n_ctr;
        end
    end

    // result queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (b_done)             r_wr_ptr <= r_wr_ptr + Q_PTR_W'(1);
            if (i_pop && !o_empty)  r_rd_ptr <= r_rd_ptr + Q_PTR_W'(1);
            r_cnt <= r_cnt + Q_CNT_W'(b_done) - Q_CNT_W'(i_pop && !o_empty);
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_done) r_rq[r_wr_ptr] <= res;
    end

    assign o_empty    = (r_cnt == '0);
    assign o_result   = r_rq[r_rd_ptr];
    assign o_head_pop = adv;
    assign o_clr_busy = r_clr_busy;

endmodule

@@ rtl/gshare_branch_predictor.sv @@
// gshare_branch_predictor: top level; ties the front end (history, hashing)
// to the back end (counter table, counts, results). Depends on gbp_pkg,
// gbp_front and gbp_back.
//
// Gshare/bimodal predictor trained by resolved branches. Each push transaction
// carries a branch PC and its actual direction; each pop transaction returns
// the prediction the 2-bit counter held before training, a mispredict flag
// and wrapping 32-bit totals of branches and mispredictions. The table index
// is pc[INDEX_BITS+1:2] with the global history XORed into its top n bits,
// where n is the history length register saturated to 12 (n = 0 is bimodal).
// Throughput is one branch per clock unless a full result queue holds the
// back end: the history update and index hash are done at push time, and the
// table's read/train/write stage bypasses its own most recent write, so
// back-to-back branches to the same counter are exact. A pushed branch passes
// the hand-off queue and the read/train/write stage register before empty
// falls. After reset the 4096-entry counter table is swept back to weakly
// taken, one entry per clock, with full held high and history length writes
// still taken. Write the history length only while no branch is in flight.
module gshare_branch_predictor import gbp_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // configuration: history length
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    // branch input queue side
    input  logic             push,
    output logic             full,
    input  logic [31:0]      i_pc,
    input  logic             i_taken,
    // result queue side
    output logic             empty,
    input  logic             pop,
    output logic             o_predicted_taken,
    output logic             o_mispredicted,
    output logic [CNT_W-1:0] o_branch_count,
    output logic [CNT_W-1:0] o_mispredict_count
);

    logic      mq_full, head_vld, head_pop, clr_busy, accept;
    t_mid_item head;
    t_result   result;

    // table sweep blocks new branches; the hand-off queue decouples the ends
    assign full   = clr_busy || mq_full;
    assign accept = push && !full;

    gbp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_push      (accept),
        .i_pc        (i_pc),
        .i_taken     (i_taken),
        .o_full      (mq_full),
        .o_head_vld  (head_vld),
        .o_head      (head),
        .i_head_pop  (head_pop)
    );

    gbp_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head_vld (head_vld),
        .i_head     (head),
        .o_head_pop (head_pop),
        .o_clr_busy (clr_busy),
        .o_empty    (empty),
        .o_result   (result),
        .i_pop      (pop)
    );

    assign o_predicted_taken  = result.predicted_taken;
    assign o_mispredicted     = result.mispredicted;
    assign o_branch_count     = result.branch_count;
    assign o_mispredict_count = result.mispredict_count;

endmodule

@@ rtl/gbp_checker.sv @@
// gbp_checker: port-level assertions for the predictor, bound to the top level.
// Depends on gbp_pkg and gshare_branch_predictor.
module gbp_checker import gbp_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             full,
    input logic             empty,
    input logic             pop,
    input logic             o_mispredicted,
    input logic [CNT_W-1:0] o_branch_count,
    input logic [CNT_W-1:0] o_mispredict_count
);

    logic [CNT_W-1:0] r_exp_bc, r_exp_mc;
    logic             out_acc;

    assign out_acc = pop && !empty;

    // totals seen so far on popped results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_bc <= '0;
            r_exp_mc <= '0;
        end else if (out_acc) begin
            r_exp_bc <= o_branch_count;
            r_exp_mc <= o_mispredict_count;
        end
    end

    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && full)
        else $error("queues not empty/blocked after reset");

    a_branch_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc |-> o_branch_count == r_exp_bc + CNT_W'(1))
        else $error("branch count skipped or repeated");

    a_miss_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc |-> o_mispredict_count == r_exp_mc + CNT_W'(o_mispredicted))
        else $error("mispredict count inconsistent with flag");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty)
        else $error("result withdrawn before pop");

endmodule

bind gshare_branch_predictor gbp_checker u_gbp_checker (.*);
